// File: sv/walu_pkg.sv
// shared types, codes and helpers of the width-selectable unsigned alu
`default_nettype none
package walu_pkg;

  // operation codes
  typedef enum logic [1:0] {
    OP_CMP = 2'd0,
    OP_INC = 2'd1,
    OP_DIV = 2'd2,
    OP_MUL = 2'd3
  } func_e;

  // operand width codes
  typedef enum logic [1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_32 = 2'd2,
    WID_64 = 2'd3
  } wid_e;

  localparam int unsigned ValW    = 64;
  localparam int unsigned FacW    = 32;
  localparam int unsigned DivSteps = ValW;
  // register stages of the side path (multiply, compare, increment) after the input register
  localparam int unsigned SideStages = 2;
  localparam int unsigned SideDelay  = DivSteps - SideStages;
  // multiplier split and full product width
  localparam int unsigned HalfW = ValW / 2;
  localparam int unsigned ProdW = ValW + FacW;

  localparam logic [ValW-1:0] Mask8  = 64'h0000_0000_0000_00FF;
  localparam logic [ValW-1:0] Mask16 = 64'h0000_0000_0000_FFFF;
  localparam logic [ValW-1:0] Mask32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [ValW-1:0] Mask64 = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OrdEq   = 2'b00;
  localparam logic [1:0] OrdGt   = 2'b01;
  localparam logic [1:0] OrdLt   = 2'b11;

  // item as it enters the pipeline, already masked to its width
  typedef struct packed {
    logic            valid;
    func_e           func;
    logic [ValW-1:0] mask;
    logic [ValW-1:0] val;
    logic [ValW-1:0] opb;
    logic [FacW-1:0] fac;
  } item_t;

  // one stage of the divider chain
  typedef struct packed {
    logic            valid;
    func_e           func;
    logic [ValW-1:0] val;
    logic [FacW-1:0] fac;
    logic [FacW-1:0] rem;
    logic [ValW-1:0] dvd;
  } div_t;

  // result of compare, increment or multiply
  typedef struct packed {
    logic [ValW-1:0] res;
    logic [1:0]      ord;
    logic            fail;
  } side_t;

  function automatic logic [ValW-1:0] width_mask(input wid_e sel);
    logic [ValW-1:0] m;
    case (sel)
      WID_8:   m = Mask8;
      WID_16:  m = Mask16;
      WID_32:  m = Mask32;
      default: m = Mask64;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: sv/walu_div_stage.sv
// one restoring divider step: one quotient bit per stage
`default_nettype none
module walu_div_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire walu_pkg::div_t stage_i,
  output walu_pkg::div_t     stage_o
);

  logic [walu_pkg::FacW:0]   trial;
  logic [walu_pkg::FacW:0]   diff;
  logic                      qbit;
  walu_pkg::div_t            stage_d;
  walu_pkg::div_t            stage_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial   = {stage_i.rem, stage_i.dvd[walu_pkg::ValW-1]};
    diff    = trial - {1'b0, stage_i.fac};
    qbit    = (trial >= {1'b0, stage_i.fac});
    stage_d = stage_i;
    stage_d.rem = qbit ? diff[walu_pkg::FacW-1:0] : trial[walu_pkg::FacW-1:0];
    stage_d.dvd = {stage_i.dvd[walu_pkg::ValW-2:0], qbit};
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

// File: sv/walu_side.sv
// two-stage path for compare, increment and multiply with overflow check
`default_nettype none
module walu_side (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire walu_pkg::item_t item_i,
  output walu_pkg::side_t     side_o
);

  // first stage registers
  logic [walu_pkg::ValW-1:0] pl_d, pl_q, ph_d, ph_q;
  walu_pkg::side_t           pre_d, pre_q;
  walu_pkg::func_e           func_q;
  logic [walu_pkg::ValW-1:0] mask_q, val_q;

  // second stage
  logic [walu_pkg::ProdW-1:0] prod;
  logic [walu_pkg::ProdW-1:0] mask_w;
  logic                      ovf;
  walu_pkg::side_t           side_d, side_q;

  // partial products, compare and increment
  always_comb begin
    pl_d = item_i.val[walu_pkg::HalfW-1:0] * item_i.fac;
    ph_d = item_i.val[walu_pkg::ValW-1:walu_pkg::HalfW] * item_i.fac;
    pre_d.res  = item_i.val;
    pre_d.ord  = walu_pkg::OrdEq;
    pre_d.fail = 1'b0;
    case (item_i.func)
      walu_pkg::OP_CMP: begin
        if (item_i.val < item_i.opb) begin
          pre_d.ord = walu_pkg::OrdLt;
        end else if (item_i.val > item_i.opb) begin
          pre_d.ord = walu_pkg::OrdGt;
        end
      end
      walu_pkg::OP_INC: begin
        if (item_i.val == item_i.mask) begin
          pre_d.fail = 1'b1;
        end else begin
          pre_d.res = item_i.val + 64'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      pre_q  <= pre_d;
      func_q <= item_i.func;
      mask_q <= item_i.mask;
      val_q  <= item_i.val;
    end
  end

  // sum the partial products and check the bits above the width
  always_comb begin
    prod   = {ph_q, {walu_pkg::HalfW{1'b0}}} + {{walu_pkg::FacW{1'b0}}, pl_q};
    mask_w = {{walu_pkg::FacW{1'b0}}, mask_q};
    ovf    = |(prod & ~mask_w);
    side_d = pre_q;
    if (func_q == walu_pkg::OP_MUL) begin
      side_d.fail = ovf;
      side_d.res  = ovf ? val_q : (prod[walu_pkg::ValW-1:0] & mask_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
    end
  end

  assign side_o = side_q;

endmodule
`default_nettype wire

// File: sv/width_selectable_unsigned_alu_top.sv
// top level: input register, divider chain, side path and output register
// throughput: one request per cycle unless stalled; the 64-stage divider chain sets the latency
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset (rst_ni low, asynchronous) clears all valid bits; side path and output data are not reset
`default_nettype none
module width_selectable_unsigned_alu_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  input  wire logic [159:0] s_tdata_i,  // value_in[63:0], operand_b[127:64], scale_factor[159:128]
  input  wire logic [3:0]   s_tuser_i,  // func[1:0], width_sel[3:2]
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  output logic [71:0]       m_tdata_o   // new_value[63:0], order[65:64], failed[66], zero[71:67]
);

  logic                   en;
  walu_pkg::item_t        item_d, item_q;
  walu_pkg::div_t         div_w [walu_pkg::DivSteps+1];
  walu_pkg::side_t        side_w;
  walu_pkg::side_t        dly_q [walu_pkg::SideDelay];
  walu_pkg::side_t        out_d;
  logic                   out_valid_q;
  walu_pkg::side_t        out_q;

  // whole pipeline moves when the output register can take a request
  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  // input register with width masking
  always_comb begin
    item_d.valid = s_tvalid_i;
    item_d.func  = walu_pkg::func_e'(s_tuser_i[1:0]);
    item_d.mask  = walu_pkg::width_mask(walu_pkg::wid_e'(s_tuser_i[3:2]));
    item_d.val   = s_tdata_i[63:0] & item_d.mask;
    item_d.opb   = s_tdata_i[127:64] & item_d.mask;
    item_d.fac   = s_tdata_i[159:128];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en) begin
      item_q <= item_d;
    end
  end

  // divider chain entry
  always_comb begin
    div_w[0].valid = item_q.valid;
    div_w[0].func  = item_q.func;
    div_w[0].val   = item_q.val;
    div_w[0].fac   = item_q.fac;
    div_w[0].rem   = '0;
    div_w[0].dvd   = item_q.val;
  end

  for (genvar g = 0; g < walu_pkg::DivSteps; g++) begin : g_div
    walu_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (div_w[g]),
      .stage_o (div_w[g+1])
    );
  end

  // side path and its delay line to meet the divider
  walu_side u_side (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (item_q),
    .side_o (side_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= side_w;
      for (int i = 1; i < walu_pkg::SideDelay; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // final select
  always_comb begin
    out_d = dly_q[walu_pkg::SideDelay-1];
    if (div_w[walu_pkg::DivSteps].func == walu_pkg::OP_DIV) begin
      out_d.ord = walu_pkg::OrdEq;
      if (div_w[walu_pkg::DivSteps].fac == '0) begin
        out_d.fail = 1'b1;
        out_d.res  = div_w[walu_pkg::DivSteps].val;
      end else begin
        out_d.fail = 1'b0;
        out_d.res  = div_w[walu_pkg::DivSteps].dvd;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_w[walu_pkg::DivSteps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {5'b0, out_q.fail, out_q.ord, out_q.res};

`ifndef SYNTH
  // a compare result never reports failure
  a_ord_no_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && out_q.ord != walu_pkg::OrdEq) |-> !out_q.fail)
    else $error("compare result flagged as failed");

  // the order code 2 never appears
  a_ord_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (out_q.ord != 2'b10))
    else $error("illegal order code");

  // a stalled pipeline keeps the valid bit of the last divider stage in place
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(div_w[walu_pkg::DivSteps].valid))
    else $error("divider chain moved during stall");

  // a valid divide result with nonzero divisor fits under the dividend
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_w[walu_pkg::DivSteps].valid && div_w[walu_pkg::DivSteps].fac != '0)
      |-> (div_w[walu_pkg::DivSteps].dvd <= div_w[walu_pkg::DivSteps].val))
    else $error("quotient exceeds dividend");
`endif

endmodule
`default_nettype wire

// File: tb/walu_checker.sv
// checker: predicts each alu request and compares the results in order
`timescale 1ns / 100ps
`default_nettype none
module walu_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [159:0] s_tdata_i,
  input  wire logic [3:0]   s_tuser_i,
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  input  wire logic [71:0]  m_tdata_i,
  output int                fail_cnt_o,
  output int                pending_o
);

  typedef struct packed {
    logic [walu_pkg::ValW-1:0] value;
    logic [1:0]                ord;
    logic                      fail;
  } alu_res_t;

  alu_res_t expected_q[$];

  // compute the expected outcome of one request
  function automatic alu_res_t alu_predict(logic [159:0] data, logic [3:0] user);
    alu_res_t                  r;
    walu_pkg::func_e           op;
    logic [walu_pkg::ValW-1:0] msk, v, b, f;
    logic [127:0]              prod;
    op  = walu_pkg::func_e'(user[1:0]);
    case (walu_pkg::wid_e'(user[3:2]))
      walu_pkg::WID_8:  msk = 64'hFF;
      walu_pkg::WID_16: msk = 64'hFFFF;
      walu_pkg::WID_32: msk = 64'hFFFF_FFFF;
      default:          msk = '1;
    endcase
    v = data[63:0] & msk;
    b = data[127:64] & msk;
    f = {32'd0, data[159:128]};
    r.value = v;
    r.ord   = walu_pkg::OrdEq;
    r.fail  = 1'b0;
    case (op)
      walu_pkg::OP_CMP: begin
        if (v < b) r.ord = walu_pkg::OrdLt;
        else if (v > b) r.ord = walu_pkg::OrdGt;
      end
      walu_pkg::OP_INC: begin
        if (v == msk) r.fail = 1'b1;
        else r.value = v + 64'd1;
      end
      walu_pkg::OP_DIV: begin
        if (f == 0) r.fail = 1'b1;
        else r.value = v / f;
      end
      default: begin
        prod = {64'd0, v} * {64'd0, f};
        if (prod > {64'd0, msk}) r.fail = 1'b1;
        else r.value = prod[63:0];
      end
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // record requests and check results
  always @(posedge clk_i or negedge rst_ni) begin
    alu_res_t e;
    int       errs;
    errs = 0;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) expected_q.push_back(alu_predict(s_tdata_i, s_tuser_i));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata_i);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata_i[63:0] !== e.value) begin
            $error("new_value expected %h actual %h", e.value, m_tdata_i[63:0]);
            errs++;
          end
          if (m_tdata_i[65:64] !== e.ord) begin
            $error("order expected %0d actual %0d", e.ord, m_tdata_i[65:64]);
            errs++;
          end
          if (m_tdata_i[66] !== e.fail) begin
            $error("failed expected %0d actual %0d", e.fail, m_tdata_i[66]);
            errs++;
          end
          if (m_tdata_i[71:67] !== 5'd0) begin
            $error("pad bits expected 0 actual %h", m_tdata_i[71:67]);
            errs++;
          end
        end
      end
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench top: clock, reset, request stimulus, output stalls and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int NumRandom = 2000;
  localparam int IdleLimit = 5000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  int           fail_cnt, pending;
  int           idle_cycles = 0;
  bit           stall_on = 1'b0;

  always #4 clk_i = ~clk_i;

  width_selectable_unsigned_alu_top dut (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata)
  );

  walu_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready),
    .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // value biased toward the edges of the chosen width
  function automatic logic [63:0] edgy_value(walu_pkg::wid_e w);
    logic [63:0] m;
    m = (w == walu_pkg::WID_8) ? 64'hFF : (w == walu_pkg::WID_16) ? 64'hFFFF :
        (w == walu_pkg::WID_32) ? 64'hFFFF_FFFF : '1;
    case ($urandom_range(0, 5))
      0: return rand64() & ~m;
      1: return (rand64() & ~m) | m;
      2: return (rand64() & ~m) | (m - $urandom_range(0, 3));
      3: return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // one request, held until accepted; then a random gap or back to back
  task automatic send_req(walu_pkg::func_e op, walu_pkg::wid_e w, logic [63:0] v,
                          logic [63:0] b, logic [31:0] f, bit gap);
    s_tvalid <= 1'b1;
    s_tuser  <= {w, op};
    s_tdata  <= {f, b, v};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (gap) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // receiver stall pattern: long ready runs alternate with stalled stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
    m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  // watchdog on cycles with no accepted request and no accepted result
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int burst;
    logic [31:0] fac;
    walu_pkg::func_e op;
    walu_pkg::wid_e w;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, every operation and the special cases
    send_req(walu_pkg::OP_CMP, walu_pkg::WID_8,  64'hFFFF_FF10, 64'hAB20, 32'd0, 0);
    send_req(walu_pkg::OP_CMP, walu_pkg::WID_64, '1, '1, '1, 0);
    send_req(walu_pkg::OP_CMP, walu_pkg::WID_16, 64'h1234, 64'h1233, 32'd0, 0);
    send_req(walu_pkg::OP_CMP, walu_pkg::WID_32, 64'h0, 64'hFFFF_FFFF, 32'd0, 0);
    send_req(walu_pkg::OP_INC, walu_pkg::WID_8,  64'hFF, 0, 0, 0);
    send_req(walu_pkg::OP_INC, walu_pkg::WID_16, 64'h1_FFFE, 0, 0, 0);
    send_req(walu_pkg::OP_INC, walu_pkg::WID_32, 64'hFFFF_FFFF, 0, 0, 0);
    send_req(walu_pkg::OP_INC, walu_pkg::WID_64, '1, 0, 0, 0);
    send_req(walu_pkg::OP_INC, walu_pkg::WID_64, 64'hFFFF_FFFF, 0, 0, 0);
    send_req(walu_pkg::OP_DIV, walu_pkg::WID_64, '1, 0, 32'd0, 0);
    send_req(walu_pkg::OP_DIV, walu_pkg::WID_64, '1, 0, 32'hFFFF_FFFF, 0);
    send_req(walu_pkg::OP_DIV, walu_pkg::WID_8,  64'hFF, 0, 32'd7, 0);
    send_req(walu_pkg::OP_DIV, walu_pkg::WID_32, 64'h5, 0, 32'd9, 0);
    send_req(walu_pkg::OP_DIV, walu_pkg::WID_16, 64'hFFFF, '1, 32'd1, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_8,  64'hFF, 0, 32'd0, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_8,  64'h80, 0, 32'd2, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_8,  64'h7F, 0, 32'd2, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_32, 64'hFFFF_FFFF, 0, 32'd1, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_64, 64'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_64, 64'h1_0000_0001, 0, 32'hFFFF_FFFF, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_64, 64'h1_0000_0002, 0, 32'hFFFF_FFFF, 0);
    send_req(walu_pkg::OP_MUL, walu_pkg::WID_16, 64'h0, '1, 32'hFFFF_FFFF, 1);

    // random requests in bursts with gaps
    for (int n = 0; n < NumRandom; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        op = walu_pkg::func_e'($urandom_range(0, 3));
        w  = walu_pkg::wid_e'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: fac = 32'd0;
          1: fac = $urandom_range(1, 4);
          2: fac = $urandom >> $urandom_range(0, 31);
          default: fac = $urandom;
        endcase
        send_req(op, w, edgy_value(w), edgy_value(w), fac, k == burst - 1);
      end
    end
    s_tvalid <= 1'b0;

    // drain; the watchdog bounds this wait
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
